### design/twr_pkg.sv
// Package for the text wrap glyph column renderer.
// Holds the screen and glyph geometry, register indexes, operation codes and reset values.
// No dependencies; the top level design file and the testbench import it.
package twr_pkg;

	// Screen and font geometry
	localparam int unsigned SCREEN_WIDTH  = 800;
	localparam int unsigned SCREEN_HEIGHT = 480;
	localparam int unsigned GLYPH_COUNT   = 95;

	localparam int unsigned GLYPH_W    = 10;
	localparam int unsigned GLYPH_H    = 16;
	localparam int unsigned ADVANCE    = GLYPH_W + 1;
	localparam int unsigned LINE_STEP  = GLYPH_H + 4;
	localparam int unsigned FIRST_CODE = 32;
	localparam int unsigned NEWLINE    = 10;
	localparam int unsigned Y_MAX      = 1023;

	// Font memory: one 16-bit column per entry, GLYPH_W entries per glyph
	localparam int unsigned FONT_DEPTH = GLYPH_COUNT * GLYPH_W;
	localparam int unsigned FONT_AW    = $clog2(FONT_DEPTH);
	localparam int unsigned MASK_W     = 16;
	localparam int unsigned COL_W      = 4;

	// Configuration port
	localparam int unsigned CFG_DATA_W = 10;
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_LEFT_X       = 2'd0;
	localparam reg_idx_t REG_START_Y      = 2'd1;
	localparam reg_idx_t REG_RIGHT_LIMIT  = 2'd2;
	localparam reg_idx_t REG_BOTTOM_LIMIT = 2'd3;

	localparam logic [9:0] LEFT_X_RST       = 10'd20;
	localparam logic [8:0] START_Y_RST      = 9'd76;
	localparam logic [9:0] RIGHT_LIMIT_RST  = 10'd780;
	localparam logic [8:0] BOTTOM_LIMIT_RST = 9'd444;

	// Input operation codes
	localparam logic OP_FONT = 1'b0;
	localparam logic OP_CHAR = 1'b1;

endpackage

### design/twr_in_if.sv
// Input channel of the glyph column renderer: font loads and characters.
// Valid/ready handshake; payload widths follow the item fields. No dependencies.
interface twr_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [6:0]  glyph_index;
	logic [3:0]  glyph_column;
	logic [15:0] font_bits;
	logic [7:0]  char_code;
	logic        restart;

	modport source (output valid, op, glyph_index, glyph_column, font_bits, char_code,
		restart, input ready);
	modport sink (input valid, op, glyph_index, glyph_column, font_bits, char_code,
		restart, output ready);
endinterface

### design/twr_out_if.sv
// Output channel of the glyph column renderer: one glyph column per transaction.
// Valid/ready handshake. No dependencies.
interface twr_out_if;
	logic        valid;
	logic        ready;
	logic [9:0]  pixel_x;
	logic [9:0]  pixel_y;
	logic [15:0] column_mask;
	logic        last_column;

	modport source (output valid, pixel_x, pixel_y, column_mask, last_column, input ready);
	modport sink (input valid, pixel_x, pixel_y, column_mask, last_column, output ready);
endinterface

### design/twr_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Read data holds while no read is issued. No dependencies.
module twr_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 950
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, hold when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/text_wrap_glyph_column_renderer_top.sv
// Text wrap glyph column renderer, top level.
// Uses twr_pkg, twr_in_if, twr_out_if and twr_ram (font memory).
//
// Usage:
//   in_ch carries two kinds of transaction. op = font load writes one 16-bit
//   glyph column into the font memory in the accept cycle and gives no result.
//   op = render places one character at the cursor (restart first moves the
//   cursor to left_x / start_y), handles newline, right-edge wrap and the
//   bottom stop, then emits up to ten glyph columns on out_ch, the last one
//   flagged with last_column.
//   Sequence: a font load does not hold off the next transaction. A character
//   is accepted, goes through the wrap decision and setup, then issues one
//   font memory read per column; the next transaction is taken once its last
//   read is issued. One that draws nothing returns to idle from the wrap
//   decision or from setup. The single font memory read port sets the column rate.
//   Path: each column passes the read stage and the output register to out_ch.
//   Stall: a read stage and the output register hold their columns while
//   out_ch.ready is low; reads pause, no column is lost, and the next input
//   transaction is taken once the current character has issued its reads.
//   Reset: registers return to their defaults, the cursor to 20 / 76, the
//   stop flag clears; font memory contents stay undefined until loaded.
//   cfg_we writes register cfg_index (left_x, start_y, right_limit,
//   bottom_limit) with cfg_wdata, truncated to the register width.
module text_wrap_glyph_column_renderer_top
	import twr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  reg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	twr_in_if.sink                in_ch,
	twr_out_if.source             out_ch
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DECIDE = 2'd1;
	localparam logic [1:0] ST_PREP   = 2'd2;
	localparam logic [1:0] ST_EMIT   = 2'd3;

	logic [1:0] state_q;

	// Configuration registers
	logic [9:0] left_x_q;
	logic [8:0] start_y_q;
	logic [9:0] right_limit_q;
	logic [8:0] bottom_limit_q;

	// Cursor and character state
	logic [10:0] cur_x_q;
	logic [9:0]  cur_y_q;
	logic        stopped_q;
	logic [7:0]  code_q;

	// Per-character draw setup
	logic [10:0]        base_x_q;
	logic [9:0]         base_y_q;
	logic [MASK_W-1:0]  row_mask_q;
	logic [COL_W-1:0]   n_q;
	logic [COL_W-1:0]   col_q;
	logic [FONT_AW-1:0] base_addr_q;

	// Read stage
	logic              s1_valid_q;
	logic [9:0]        px_s1;
	logic [9:0]        py_s1;
	logic [MASK_W-1:0] mask_s1;
	logic              last_s1;

	// Output register
	logic              out_valid_q;
	logic [9:0]        out_x_q;
	logic [9:0]        out_y_q;
	logic [MASK_W-1:0] out_mask_q;
	logic              out_last_q;

	logic               accept;
	logic               font_in_range;
	logic               font_we;
	logic [FONT_AW-1:0] font_waddr;
	logic               rd_en;
	logic [FONT_AW-1:0] rd_addr;
	logic [MASK_W-1:0]  rd_data;
	logic               out_load;
	logic               col_last;

	logic        fits0;
	logic        fits1;
	logic        wrap;
	logic [10:0] y_step;
	logic [9:0]  y_brk;
	logic [9:0]  y_wr;
	logic [10:0] x_wr;
	logic        is_newline;
	logic        printable;
	logic [8:0]  glyph_off;

	logic [7:0]         glyph_num;
	logic [FONT_AW-1:0] glyph_addr;
	logic [11:0]        x_room;
	logic [COL_W-1:0]   n_cols;
	logic [10:0]        y_room;
	logic [MASK_W-1:0]  mask_calc;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;

	// Font load decode
	assign font_in_range = ({1'b0, in_ch.glyph_index} < 8'(GLYPH_COUNT))
		&& (in_ch.glyph_column < 4'(GLYPH_W));
	assign font_we    = accept && (in_ch.op == OP_FONT) && font_in_range;
	assign font_waddr = FONT_AW'(FONT_AW'(in_ch.glyph_index) * FONT_AW'(GLYPH_W)
		+ FONT_AW'(in_ch.glyph_column));

	// Wrap and bottom decision from the current cursor
	always_comb begin
		fits0      = ({1'b0, cur_y_q} + 11'(GLYPH_H)) <= {2'b0, bottom_limit_q};
		y_step     = {1'b0, cur_y_q} + 11'(LINE_STEP);
		y_brk      = (y_step > 11'(Y_MAX)) ? 10'(Y_MAX) : y_step[9:0];
		wrap       = ({1'b0, cur_x_q} + 12'(ADVANCE)) > {2'b0, right_limit_q};
		y_wr       = wrap ? y_brk : cur_y_q;
		x_wr       = wrap ? {1'b0, left_x_q} : cur_x_q;
		fits1      = ({1'b0, y_wr} + 11'(GLYPH_H)) <= {2'b0, bottom_limit_q};
		is_newline = (code_q == 8'(NEWLINE));
		glyph_off  = {1'b0, code_q} - 9'(FIRST_CODE);
		printable  = (code_q >= 8'(FIRST_CODE)) && (glyph_off < 9'(GLYPH_COUNT));
	end

	// Column count and row mask for the glyph at the cursor
	always_comb begin
		glyph_num  = code_q - 8'(FIRST_CODE);
		glyph_addr = FONT_AW'(FONT_AW'(glyph_num) * FONT_AW'(GLYPH_W));
		x_room     = 12'(SCREEN_WIDTH) - {1'b0, cur_x_q};
		if ({1'b0, cur_x_q} >= 12'(SCREEN_WIDTH)) begin
			n_cols = '0;
		end else if (x_room >= 12'(GLYPH_W)) begin
			n_cols = COL_W'(GLYPH_W);
		end else begin
			n_cols = x_room[COL_W-1:0];
		end
		y_room = 11'(SCREEN_HEIGHT) - {1'b0, cur_y_q};
		if ({1'b0, cur_y_q} >= 11'(SCREEN_HEIGHT)) begin
			mask_calc = '0;
		end else if (y_room >= 11'(GLYPH_H)) begin
			mask_calc = '1;
		end else begin
			mask_calc = (MASK_W'(1) << y_room[3:0]) - MASK_W'(1);
		end
	end

	// Read issue: advance only when the read stage can move on
	assign out_load = s1_valid_q && (!out_valid_q || out_ch.ready);
	assign rd_en    = (state_q == ST_EMIT) && (!s1_valid_q || out_load);
	assign rd_addr  = base_addr_q + FONT_AW'(col_q);
	assign col_last = (col_q == (n_q - COL_W'(1)));

	twr_ram #(
		.WIDTH (MASK_W),
		.DEPTH (FONT_DEPTH)
	) u_font_ram (
		.clk   (clk),
		.we    (font_we),
		.waddr (font_waddr),
		.wdata (in_ch.font_bits),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_x_q       <= LEFT_X_RST;
			start_y_q      <= START_Y_RST;
			right_limit_q  <= RIGHT_LIMIT_RST;
			bottom_limit_q <= BOTTOM_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEFT_X:       left_x_q       <= cfg_wdata[9:0];
				REG_START_Y:      start_y_q      <= cfg_wdata[8:0];
				REG_RIGHT_LIMIT:  right_limit_q  <= cfg_wdata[9:0];
				REG_BOTTOM_LIMIT: bottom_limit_q <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	// Character sequencer and cursor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cur_x_q   <= {1'b0, LEFT_X_RST};
			cur_y_q   <= {1'b0, START_Y_RST};
			stopped_q <= 1'b0;
			code_q    <= '0;
			col_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (in_ch.op == OP_CHAR)) begin
						code_q <= in_ch.char_code;
						if (in_ch.restart) begin
							cur_x_q   <= {1'b0, left_x_q};
							cur_y_q   <= {1'b0, start_y_q};
							stopped_q <= 1'b0;
						end
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					state_q <= ST_IDLE;
					if (!stopped_q) begin
						if (!fits0) begin
							stopped_q <= 1'b1;
						end else if (is_newline) begin
							cur_x_q <= {1'b0, left_x_q};
							cur_y_q <= y_brk;
						end else begin
							cur_x_q <= x_wr;
							cur_y_q <= y_wr;
							if (!fits1) begin
								stopped_q <= 1'b1;
							end else if (printable) begin
								state_q <= ST_PREP;
							end
						end
					end
				end
				ST_PREP: begin
					cur_x_q <= cur_x_q + 11'(ADVANCE);
					col_q   <= '0;
					state_q <= (n_cols == '0) ? ST_IDLE : ST_EMIT;
				end
				ST_EMIT: begin
					if (rd_en) begin
						col_q <= col_q + COL_W'(1);
						if (col_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Latch draw setup for the character
	always_ff @(posedge clk) begin
		if (state_q == ST_PREP) begin
			base_x_q    <= cur_x_q;
			base_y_q    <= cur_y_q;
			row_mask_q  <= mask_calc;
			n_q         <= n_cols;
			base_addr_q <= glyph_addr;
		end
	end

	// Read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rd_en) begin
				s1_valid_q <= 1'b1;
			end else if (out_load) begin
				s1_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Read stage and output payload
	always_ff @(posedge clk) begin
		if (rd_en) begin
			px_s1   <= 10'(base_x_q + 11'(col_q));
			py_s1   <= base_y_q;
			mask_s1 <= row_mask_q;
			last_s1 <= col_last;
		end
		if (out_load) begin
			out_x_q    <= px_s1;
			out_y_q    <= py_s1;
			out_mask_q <= rd_data & mask_s1;
			out_last_q <= last_s1;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.pixel_x     = out_x_q;
	assign out_ch.pixel_y     = out_y_q;
	assign out_ch.column_mask = out_mask_q;
	assign out_ch.last_column = out_last_q;

	// Font loads and column reads never share a cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(font_we && rd_en))
		else $error("font write and column read in the same cycle");

	// A stalled read stage keeps its column
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !out_load |=> s1_valid_q && $stable(px_s1) && $stable(last_s1))
		else $error("read stage lost a stalled column");

	// Column counter stays inside the drawn columns
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (col_q < n_q) && !stopped_q)
		else $error("column counter out of range while emitting");

	// A column moved to the output register is offered next cycle
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_ch.valid)
		else $error("loaded column not presented");

endmodule

### tb/tb_text_wrap_glyph_column_renderer_top.sv
// Testbench for the text wrap glyph column renderer: font loads, character layout and
// glyph column output checked against a cycle-free layout predictor in a scoreboard class.
// Depends on twr_pkg, twr_in_if, twr_out_if and text_wrap_glyph_column_renderer_top.
`timescale 1ns / 1ps

module tb_text_wrap_glyph_column_renderer_top;
	import twr_pkg::*;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 24;
	localparam int MAX_REPORTS   = 10;

	typedef struct packed {
		logic        op;
		logic [6:0]  glyph_index;
		logic [3:0]  glyph_column;
		logic [15:0] font_bits;
		logic [7:0]  char_code;
		logic        restart;
	} twr_item_t;

	typedef struct packed {
		logic [9:0]        pixel_x;
		logic [9:0]        pixel_y;
		logic [MASK_W-1:0] column_mask;
		logic              last_column;
	} glyph_col_t;

	typedef enum {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_t;

	// Layout predictor and queue of glyph columns still owed by the block
	class glyph_column_scoreboard;
		logic [MASK_W-1:0] font_mem [FONT_DEPTH];
		logic [9:0]        left_x;
		logic [8:0]        start_y;
		logic [9:0]        right_limit;
		logic [8:0]        bottom_limit;
		logic [10:0]       cur_x;
		logic [9:0]        cur_y;
		bit                stopped;
		glyph_col_t        pending_columns[$];
		int                mismatches;
		int                columns_checked;

		function new();
			left_x          = LEFT_X_RST;
			start_y         = START_Y_RST;
			right_limit     = RIGHT_LIMIT_RST;
			bottom_limit    = BOTTOM_LIMIT_RST;
			cur_x           = {1'b0, LEFT_X_RST};
			cur_y           = {1'b0, START_Y_RST};
			stopped         = 1'b0;
			mismatches      = 0;
			columns_checked = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_LEFT_X:       left_x = val;
				REG_START_Y:      start_y = val[8:0];
				REG_RIGHT_LIMIT:  right_limit = val;
				REG_BOTTOM_LIMIT: bottom_limit = val[8:0];
				default: ;
			endcase
		endfunction

		function void line_break();
			int unsigned next_y;
			next_y = cur_y + LINE_STEP;
			cur_x  = {1'b0, left_x};
			cur_y  = (next_y > Y_MAX) ? 10'(Y_MAX) : 10'(next_y);
		endfunction

		function bit line_fits();
			return (cur_y + GLYPH_H) <= bottom_limit;
		endfunction

		// Apply one accepted transaction and queue the columns it draws
		function void note_input(twr_item_t it);
			int unsigned       base;
			int unsigned       px;
			int unsigned       rows_left;
			int                drawn;
			logic [MASK_W-1:0] row_mask;
			glyph_col_t        col;

			if (it.op == OP_FONT) begin
				if (it.glyph_index < GLYPH_COUNT && it.glyph_column < GLYPH_W)
					font_mem[it.glyph_index * GLYPH_W + it.glyph_column] = it.font_bits;
				return;
			end
			if (it.restart) begin
				cur_x   = {1'b0, left_x};
				cur_y   = {1'b0, start_y};
				stopped = 1'b0;
			end
			if (stopped)
				return;
			if (!line_fits()) begin
				stopped = 1'b1;
				return;
			end
			if (it.char_code == NEWLINE) begin
				line_break();
				return;
			end
			if (cur_x + ADVANCE > right_limit)
				line_break();
			if (!line_fits()) begin
				stopped = 1'b1;
				return;
			end
			if (it.char_code < FIRST_CODE || it.char_code - FIRST_CODE >= GLYPH_COUNT)
				return;

			// Clear rows that fall below the screen
			if (cur_y >= SCREEN_HEIGHT) begin
				row_mask = '0;
			end else begin
				rows_left = SCREEN_HEIGHT - cur_y;
				row_mask  = (rows_left >= GLYPH_H) ? '1 : MASK_W'((32'd1 << rows_left) - 1);
			end

			base  = (it.char_code - FIRST_CODE) * GLYPH_W;
			drawn = 0;
			for (int unsigned c = 0; c < GLYPH_W; c++) begin
				px = cur_x + c;
				if (px >= SCREEN_WIDTH)
					continue;
				col.pixel_x     = 10'(px);
				col.pixel_y     = cur_y;
				col.column_mask = font_mem[base + c] & row_mask;
				col.last_column = 1'b0;
				pending_columns.push_back(col);
				drawn++;
			end
			if (drawn > 0)
				pending_columns[pending_columns.size() - 1].last_column = 1'b1;
			cur_x = 11'(cur_x + ADVANCE);
		endfunction

		// Compare one accepted output transaction with the oldest owed column
		function void check_column(glyph_col_t got);
			glyph_col_t want;
			columns_checked++;
			if (pending_columns.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected column: x=%0d y=%0d mask=%h last=%0b",
						got.pixel_x, got.pixel_y, got.column_mask, got.last_column);
				return;
			end
			want = pending_columns.pop_front();
			if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
					got.column_mask !== want.column_mask ||
					got.last_column !== want.last_column) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("column mismatch: want x=%0d y=%0d mask=%h last=%0b, got x=%0d y=%0d mask=%h last=%0b",
						want.pixel_x, want.pixel_y, want.column_mask, want.last_column,
						got.pixel_x, got.pixel_y, got.column_mask, got.last_column);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	reg_idx_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	twr_in_if  in_ch();
	twr_out_if out_ch();

	text_wrap_glyph_column_renderer_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	glyph_column_scoreboard sb;
	int cycles;
	int burst_left;
	int calm_left;
	int n_chars;
	int n_fonts;
	int n_settings;

	always #10 clk = ~clk;

	always @(posedge clk)
		cycles <= cycles + 1;

	// Give up on a hung run
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT)
			@(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	// Output side: switch at random among always-ready, coin-flip, mostly-ready and periodic stall patterns
	initial begin
		rx_mode_t mode;
		int       mode_left;
		int       period;
		int       stall_len;
		int       phase_cnt;
		out_ch.ready = 1'b0;
		mode_left    = 0;
		mode         = RX_ALWAYS;
		period       = 4;
		stall_len    = 1;
		phase_cnt    = 0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode      = rx_mode_t'($urandom_range(RX_ALWAYS, RX_PERIODIC));
				mode_left = $urandom_range(40, 160);
				period    = $urandom_range(4, 16);
				stall_len = $urandom_range(1, (period > 9) ? 8 : period - 1);
				phase_cnt = 0;
			end
			mode_left--;
			case (mode)
				RX_ALWAYS: out_ch.ready <= 1'b1;
				RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
				RX_MOSTLY: out_ch.ready <= ($urandom_range(0, 99) < 85);
				default: begin
					out_ch.ready <= (phase_cnt >= stall_len);
					phase_cnt = (phase_cnt + 1) % period;
				end
			endcase
		end
	end

	// Check every accepted output transaction
	always @(posedge clk)
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
			sb.check_column('{out_ch.pixel_x, out_ch.pixel_y, out_ch.column_mask,
				out_ch.last_column});

	function automatic twr_item_t font_item(int g, int c, logic [15:0] bits);
		twr_item_t it;
		it              = '0;
		it.op           = OP_FONT;
		it.glyph_index  = 7'(g);
		it.glyph_column = 4'(c);
		it.font_bits    = bits;
		it.char_code    = 8'($urandom);
		return it;
	endfunction

	function automatic twr_item_t char_item(logic [7:0] code, logic rst);
		twr_item_t it;
		it              = '0;
		it.op           = OP_CHAR;
		it.glyph_index  = 7'($urandom);
		it.glyph_column = 4'($urandom);
		it.font_bits    = 16'($urandom);
		it.char_code    = code;
		it.restart      = rst;
		return it;
	endfunction

	// Glyphs whose every column gets loaded; characters only draw these
	function automatic bit glyph_loaded(int unsigned g);
		return (g % 8 == 0) || (g == 33) || (g == GLYPH_COUNT - 1);
	endfunction

	// Mostly printable text with newlines, some control and high codes, a few font loads
	function automatic twr_item_t random_item();
		twr_item_t   it;
		int          pick;
		int unsigned code;
		logic [15:0] bits;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			bits = 16'($urandom);
			if ($urandom_range(0, 7) == 0)
				bits = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			it = font_item(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
				: $urandom_range(0, GLYPH_COUNT - 1),
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
				: $urandom_range(0, GLYPH_W - 1), bits);
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				do
					code = $urandom_range(FIRST_CODE, FIRST_CODE + GLYPH_COUNT - 1);
				while (!glyph_loaded(code - FIRST_CODE));
				it = char_item(8'(code), 1'b0);
			end else if (pick < 84)
				it = char_item(8'(NEWLINE), 1'b0);
			else if (pick < 92)
				it = char_item(8'($urandom_range(FIRST_CODE + GLYPH_COUNT, 255)), 1'b0);
			else
				it = char_item(8'($urandom_range(0, FIRST_CODE - 1)), 1'b0);
			it.restart = sb.stopped ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 24) == 0);
		end
		return it;
	endfunction

	// Send one transaction; bursts of random length with random gaps between them
	task automatic send_item(twr_item_t it);
		int gap;
		if (burst_left == 0) begin
			if (calm_left == 0 && $urandom_range(0, 7) == 0)
				calm_left = $urandom_range(20, 60);
			gap = (calm_left > 0) ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				@(negedge clk);
				in_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		@(negedge clk);
		in_ch.op           <= it.op;
		in_ch.glyph_index  <= it.glyph_index;
		in_ch.glyph_column <= it.glyph_column;
		in_ch.font_bits    <= it.font_bits;
		in_ch.char_code    <= it.char_code;
		in_ch.restart      <= it.restart;
		in_ch.valid        <= 1'b1;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		sb.note_input(it);
		if (it.op == OP_FONT)
			n_fonts++;
		else
			n_chars++;
		burst_left--;
		if (calm_left > 0)
			calm_left--;
	endtask

	// Hold the input side until every owed column has come out
	task automatic drain_outputs(int settle);
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (sb.pending_columns.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		sb.write_reg(idx, val);
	endtask

	// Reprogram all four registers, then run a stream of random transactions
	task automatic run_phase(logic [9:0] lx, logic [9:0] sy, logic [9:0] rl,
			logic [9:0] bl, int n_items);
		twr_item_t it;
		drain_outputs(SETTLE_CYCLES);
		write_reg(REG_LEFT_X, lx);
		write_reg(REG_START_Y, sy);
		write_reg(REG_RIGHT_LIMIT, rl);
		write_reg(REG_BOTTOM_LIMIT, bl);
		@(negedge clk);
		cfg_we <= 1'b0;
		n_settings++;
		for (int i = 0; i < n_items; i++) begin
			if (i == n_items / 2)
				drain_outputs(0);
			it = random_item();
			if (i == 0)
				it = char_item(it.char_code, 1'b1);
			send_item(it);
		end
	endtask

	initial begin
		int          lx;
		int          sy;
		twr_item_t   directed[$];
		sb = new();
		burst_left = 0;
		calm_left  = 0;
		n_chars    = 0;
		n_fonts    = 0;
		n_settings = 1;

		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = REG_LEFT_X;
		cfg_wdata          = '0;
		in_ch.valid        = 1'b0;
		in_ch.op           = OP_FONT;
		in_ch.glyph_index  = '0;
		in_ch.glyph_column = '0;
		in_ch.font_bits    = '0;
		in_ch.char_code    = '0;
		in_ch.restart      = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Load every glyph that characters use so that none reads an unwritten column
		for (int g = 0; g < GLYPH_COUNT; g++)
			if (glyph_loaded(g))
				for (int c = 0; c < GLYPH_W; c++)
					send_item(font_item(g, c, 16'($urandom)));

		// Directed: field extremes, ignored loads, unknown codes and newline
		directed.push_back(font_item(GLYPH_COUNT - 1, GLYPH_W - 1, 16'hFFFF));
		directed.push_back(font_item(0, 0, 16'h0000));
		directed.push_back(font_item(127, 15, 16'hFFFF));
		directed.push_back(font_item(GLYPH_COUNT, 0, 16'h1234));
		directed.push_back(font_item(3, GLYPH_W, 16'hFFFF));
		directed.push_back(char_item(8'h7E, 1'b1));
		directed.push_back(char_item(8'h20, 1'b0));
		directed.push_back(char_item(8'h7F, 1'b0));
		directed.push_back(char_item(8'hFF, 1'b0));
		directed.push_back(char_item(8'h00, 1'b0));
		directed.push_back(char_item(8'h1F, 1'b0));
		directed.push_back(char_item(8'(NEWLINE), 1'b0));
		directed.push_back(char_item(8'(NEWLINE), 1'b0));
		directed.push_back(char_item(8'h41, 1'b0));
		directed.push_back(char_item(8'h80, 1'b0));
		directed.push_back(font_item(8'h41 - FIRST_CODE, 4, 16'hA5A5));
		directed.push_back(char_item(8'h41, 1'b0));
		directed.push_back(char_item(8'h41, 1'b1));
		directed.push_back(char_item(8'(NEWLINE), 1'b1));
		directed.push_back(char_item(8'h7E, 1'b0));
		foreach (directed[i])
			send_item(directed[i]);

		// Random phases over extreme and ordinary register settings
		run_phase(10'd799, 10'd0, 10'd800, 10'd480, 20);
		run_phase(10'd0, 10'd0, 10'd0, 10'd0, 10);
		run_phase(10'd799, 10'd479, 10'd800, 10'd480, 8);
		run_phase(10'd0, 10'h3DA, 10'd800, 10'h3FF, 20);
		run_phase(10'd795, 10'd200, 10'h3FF, 10'd480, 20);
		repeat (3) begin
			lx = $urandom_range(0, 700);
			sy = $urandom_range(0, 300);
			run_phase(10'(lx), 10'(sy), 10'(lx + $urandom_range(11, 60)),
				10'(sy + $urandom_range(16, 90)), 15);
		end
		run_phase(10'($urandom_range(0, 799)), 10'($urandom_range(0, 479)),
			10'($urandom_range(0, 800)), 10'($urandom_range(0, 480)), 15);
		run_phase(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom), 15);
		run_phase(LEFT_X_RST, 10'(START_Y_RST), RIGHT_LIMIT_RST, 10'(BOTTOM_LIMIT_RST), 20);

		drain_outputs(SETTLE_CYCLES);

		$display("Sent %0d transactions (%0d characters, %0d font loads) over %0d register settings",
			n_chars + n_fonts, n_chars, n_fonts, n_settings);
		$display("Checked %0d glyph columns: %0d mismatches, %0d still owed",
			sb.columns_checked, sb.mismatches, sb.pending_columns.size());
		if (sb.mismatches == 0 && sb.pending_columns.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

### filelist.f
design/twr_pkg.sv
design/twr_in_if.sv
design/twr_out_if.sv
design/twr_ram.sv
design/text_wrap_glyph_column_renderer_top.sv
tb/tb_text_wrap_glyph_column_renderer_top.sv
